// ===== rtl/ipv4v_pkg.sv =====
// ipv4v_pkg: status codes, character constants and the octet judge
// shared by the dotted-quad validator modules; no dependencies
package ipv4v_pkg;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_LENGTH    = 3'd1;
	localparam logic [2:0] ST_EMPTY     = 3'd2;
	localparam logic [2:0] ST_NON_DIGIT = 3'd3;
	localparam logic [2:0] ST_OCT_OVER  = 3'd4;
	localparam logic [2:0] ST_LAST_OVER = 3'd5;
	localparam logic [2:0] ST_DOTS      = 3'd6;

	localparam logic [7:0] CH_DOT  = 8'h2E;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;

	localparam logic [4:0] LEN_MIN = 5'd7;
	localparam logic [4:0] LEN_MAX = 5'd15;
	localparam logic [4:0] LEN_SAT = 5'd16;
	localparam logic [8:0] OCT_MAX = 9'd255;
	localparam logic [8:0] OCT_SAT = 9'd256;
	localparam logic [2:0] DOTS_NEEDED = 3'd3;
	localparam logic [2:0] DOTS_SAT    = 3'd4;

	// verdict on a closed octet; over_code differs for the final octet
	function automatic logic [2:0] judge_octet(
		input logic       nonempty,
		input logic       bad_char,
		input logic [8:0] value,
		input logic [2:0] over_code
	);
		logic [2:0] res;
		if (!nonempty) begin
			res = ST_EMPTY;
		end else if (bad_char) begin
			res = ST_NON_DIGIT;
		end else if (value > OCT_MAX) begin
			res = over_code;
		end else begin
			res = ST_OK;
		end
		return res;
	endfunction

endpackage

// ===== rtl/ipv4v_scan.sv =====
// ipv4v_scan: per-string scan state and the single-pass update for one beat
// depends on ipv4v_pkg
module ipv4v_scan (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic       has_char,
	input  logic [7:0] ch,
	input  logic       last,
	output logic [2:0] status
);

	logic [4:0] char_count_q;
	logic [8:0] octet_value_q;
	logic       octet_nonempty_q;
	logic       octet_bad_char_q;
	logic [2:0] dot_count_q;
	logic [2:0] first_error_q;

	logic [4:0]  char_count_n;
	logic [8:0]  octet_value_n;
	logic        octet_nonempty_n;
	logic        octet_bad_char_n;
	logic [2:0]  dot_count_n;
	logic [2:0]  first_error_n;
	logic        is_dot;
	logic        is_digit;
	logic [3:0]  digit_raw;
	logic [12:0] acc;
	logic [2:0]  dot_err;
	logic [2:0]  tail_err;

	assign is_dot    = (ch == ipv4v_pkg::CH_DOT);
	assign is_digit  = (ch >= ipv4v_pkg::CH_ZERO) && (ch <= ipv4v_pkg::CH_NINE);
	assign digit_raw = 4'(ch - ipv4v_pkg::CH_ZERO);
	assign acc       = {4'b0, octet_value_q} * 13'd10 + {9'b0, digit_raw};
	assign dot_err   = ipv4v_pkg::judge_octet(octet_nonempty_q, octet_bad_char_q,
		octet_value_q, ipv4v_pkg::ST_OCT_OVER);

	always_comb begin
		char_count_n     = char_count_q;
		octet_value_n    = octet_value_q;
		octet_nonempty_n = octet_nonempty_q;
		octet_bad_char_n = octet_bad_char_q;
		dot_count_n      = dot_count_q;
		first_error_n    = first_error_q;
		if (has_char) begin
			if (char_count_q < ipv4v_pkg::LEN_SAT) begin
				char_count_n = char_count_q + 5'd1;
			end
			if (is_dot) begin
				if (first_error_q == ipv4v_pkg::ST_OK) begin
					first_error_n = dot_err;
				end
				if (dot_count_q < ipv4v_pkg::DOTS_SAT) begin
					dot_count_n = dot_count_q + 3'd1;
				end
				octet_value_n    = '0;
				octet_nonempty_n = 1'b0;
				octet_bad_char_n = 1'b0;
			end else begin
				octet_nonempty_n = 1'b1;
				if (is_digit) begin
					// long digit runs pin at 256
					octet_value_n = (acc > {4'b0, ipv4v_pkg::OCT_SAT}) ?
						ipv4v_pkg::OCT_SAT : acc[8:0];
				end else begin
					octet_bad_char_n = 1'b1;
				end
			end
		end
	end

	assign tail_err = ipv4v_pkg::judge_octet(octet_nonempty_n, octet_bad_char_n,
		octet_value_n, ipv4v_pkg::ST_LAST_OVER);

	always_comb begin
		if (char_count_n < ipv4v_pkg::LEN_MIN || char_count_n > ipv4v_pkg::LEN_MAX) begin
			status = ipv4v_pkg::ST_LENGTH;
		end else if (first_error_n != ipv4v_pkg::ST_OK) begin
			status = first_error_n;
		end else if (tail_err != ipv4v_pkg::ST_OK) begin
			status = tail_err;
		end else if (dot_count_n != ipv4v_pkg::DOTS_NEEDED) begin
			status = ipv4v_pkg::ST_DOTS;
		end else begin
			status = ipv4v_pkg::ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			char_count_q     <= '0;
			octet_value_q    <= '0;
			octet_nonempty_q <= 1'b0;
			octet_bad_char_q <= 1'b0;
			dot_count_q      <= '0;
			first_error_q    <= '0;
		end else if (step) begin
			if (last) begin
				// string done, start fresh
				char_count_q     <= '0;
				octet_value_q    <= '0;
				octet_nonempty_q <= 1'b0;
				octet_bad_char_q <= 1'b0;
				dot_count_q      <= '0;
				first_error_q    <= '0;
			end else begin
				char_count_q     <= char_count_n;
				octet_value_q    <= octet_value_n;
				octet_nonempty_q <= octet_nonempty_n;
				octet_bad_char_q <= octet_bad_char_n;
				dot_count_q      <= dot_count_n;
				first_error_q    <= first_error_n;
			end
		end
	end

endmodule

// ===== rtl/ipv4_dotted_quad_validator_top.sv =====
// IPv4 dotted-quad validator.
// Input channel: in_valid / in_stall carry one character beat (has_char, ch,
// last); a string is its characters with last on the final beat, and an empty
// string is a single beat with has_char low and last high.
// Output channel: out_valid / out_stall carry one status beat per string,
// produced by the beat with last set: 0 ok, 1 length, 2 empty octet,
// 3 non-digit, 4 octet over 255, 5 final octet over 255, 6 dot count.
// A beat is taken at a clock edge with valid high and stall low.
// The last beat is held in the input register, and its status is registered
// in the status register once that register is free.
// Throughput: one beat per cycle while in_stall is low; the scan is a single pass
// between the input register and the status register.
// When the receiver stalls, the status register holds; further character
// beats still flow in, and only a second last beat waits in the input
// register, which then raises in_stall.
// Reset (arst_n low) empties both registers and clears the scan state.
// depends on ipv4v_pkg and ipv4v_scan
module ipv4_dotted_quad_validator_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       has_char,
	input  logic [7:0] ch,
	input  logic       last,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [2:0] status
);

	logic       valid_s1;
	logic       has_char_s1;
	logic [7:0] ch_s1;
	logic       last_s1;
	logic       advance;
	logic       in_take;
	logic [2:0] status_n;
	logic       out_valid_q;
	logic [2:0] status_q;

	// a non-last beat never needs the output slot
	assign advance  = valid_s1 && (!last_s1 || !out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			has_char_s1 <= has_char;
			ch_s1       <= ch;
			last_s1     <= last;
		end
	end

	ipv4v_scan u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (advance),
		.has_char (has_char_s1),
		.ch       (ch_s1),
		.last     (last_s1),
		.status   (status_n)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			status_q <= status_n;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;

endmodule
